@@ rtl/shabh_pkg.sv @@
// shared types, constants and command/status structs of the sha-256 byte stream hasher
// no dependencies, compiled first
package shabh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t digest_t [8];

  // input action codes
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE           = 8'h80;
  localparam logic [5:0] LEN_START          = 6'd56;
  localparam logic [5:0] LAST_SLOT          = 6'd63;
  localparam logic [5:0] LAST_ROUND         = 6'd63;
  localparam logic [5:0] SCHED_LOAD_ROUNDS  = 6'd16;
  localparam logic [2:0] LAST_WORD_IDX      = 3'd7;

  localparam digest_t HASH_IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD1,
    S_PADZ,
    S_PADL,
    S_COMP,
    S_FOLD
  } state_t;

  // what follows the compression of the current block
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_LAST
  } blk_t;

  // source of a byte pushed into the block buffer
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } src_t;

  typedef struct packed {
    logic       push;
    src_t       src;
    logic       load_len;
    logic       init_v;
    logic       round;
    logic [5:0] round_idx;
    logic       fold;
    logic       fold_last;
  } cmd_t;

  typedef struct packed {
    logic [5:0] pending;
    logic       out_busy;
  } sts_t;

endpackage

@@ rtl/shabh_if.sv @@
// valid/ready channel interfaces of the hasher: byte request in, digest word out
// no dependencies
interface shabh_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface shabh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

@@ rtl/shabh_ctrl.sv @@
// controller fsm: byte intake, padding sequence, round count and fold
// depends on shabh_pkg
module shabh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  output logic             in_ready,
  input  shabh_pkg::sts_t  sts,
  output shabh_pkg::cmd_t  cmd
);
  import shabh_pkg::*;

  state_t     state_r, state_nxt;
  blk_t       blk_r, blk_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic       blk_full;

  assign blk_full = (sts.pending == LAST_SLOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      blk_r   <= BLK_DATA;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      blk_r   <= blk_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    rnd_nxt   = rnd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_FINISH) begin
            state_nxt = S_PAD1;
          end else if (blk_full) begin
            state_nxt = S_COMP;
            blk_nxt   = BLK_DATA;
          end
        end
      end
      S_PAD1: begin
        if (blk_full) begin
          state_nxt = S_COMP;
          blk_nxt   = BLK_PAD;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts.pending == LEN_START) begin
          state_nxt = S_PADL;
        end else if (blk_full) begin
          state_nxt = S_COMP;
          blk_nxt   = BLK_PAD;
        end
      end
      S_PADL: begin
        if (blk_full) begin
          state_nxt = S_COMP;
          blk_nxt   = BLK_LAST;
        end
      end
      S_COMP: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        case (blk_r)
          BLK_DATA: state_nxt = S_IDLE;
          BLK_PAD:  state_nxt = S_PADZ;
          BLK_LAST: begin
            if (!sts.out_busy) begin
              state_nxt = S_IDLE;
            end
          end
          default:  state_nxt = S_IDLE;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.src       = SRC_DATA;
    cmd.round_idx = rnd_r;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_ABSORB) begin
            cmd.push   = 1'b1;
            cmd.init_v = blk_full;
          end else begin
            cmd.load_len = 1'b1;
          end
        end
      end
      S_PAD1: begin
        cmd.push   = 1'b1;
        cmd.src    = SRC_PAD;
        cmd.init_v = blk_full;
      end
      S_PADZ: begin
        if (sts.pending != LEN_START) begin
          cmd.push   = 1'b1;
          cmd.src    = SRC_ZERO;
          cmd.init_v = blk_full;
        end
      end
      S_PADL: begin
        cmd.push   = 1'b1;
        cmd.src    = SRC_LEN;
        cmd.init_v = blk_full;
      end
      S_COMP: begin
        cmd.round = 1'b1;
      end
      S_FOLD: begin
        case (blk_r)
          BLK_LAST: begin
            cmd.fold      = !sts.out_busy;
            cmd.fold_last = !sts.out_busy;
          end
          default: cmd.fold = 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  // rounds run back to back once started
  a_round_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && rnd_r != LAST_ROUND)
      |=> (state_r == S_COMP && rnd_r == 6'($past(rnd_r) + 6'd1)))
    else $error("round counter did not advance");

  // a full block always starts compression at round zero
  a_full_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && blk_full) |=> (state_r == S_COMP && rnd_r == 6'd0))
    else $error("full block did not start compression at round zero");

  // digest never overwrites an undrained one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold_last |-> !sts.out_busy)
    else $error("digest loaded while output busy");

  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD && blk_r == BLK_LAST && !sts.out_busy) |=> state_r == S_IDLE)
    else $error("final fold did not return to idle");

endmodule

@@ rtl/shabh_dp.sv @@
// datapath: byte packing, schedule window, round unit, chaining words, length counters
// depends on shabh_pkg
module shabh_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  shabh_pkg::cmd_t    cmd,
  output logic [5:0]         pending,
  output shabh_pkg::digest_t dig
);
  import shabh_pkg::*;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t ch_fn(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t maj_fn(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

  logic [5:0]  pend_r, pend_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [23:0] acc_r, acc_nxt;
  word_t       win_r [16];
  word_t       win_nxt [16];
  digest_t     h_r, h_nxt;
  digest_t     v_r, v_nxt;
  digest_t     sum;
  logic [7:0]  push_byte;
  word_t       sched_w, t1, t2;

  assign pending = pend_r;
  assign dig     = sum;

  always_comb begin
    case (cmd.src)
      SRC_DATA: push_byte = in_byte;
      SRC_PAD:  push_byte = PAD_BYTE;
      SRC_ZERO: push_byte = 8'h00;
      SRC_LEN:  push_byte = len_r[63:56];
      default:  push_byte = 8'h00;
    endcase
  end

  // one round of compression
  always_comb begin
    sched_w = win_r[0];
    if (cmd.round_idx >= SCHED_LOAD_ROUNDS) begin
      sched_w = win_r[0] + ssig0(win_r[1]) + win_r[9] + ssig1(win_r[14]);
    end
    t1 = v_r[7] + bsig1(v_r[4]) + ch_fn(v_r[4], v_r[5], v_r[6]) + ROUND_K[cmd.round_idx]
       + sched_w;
    t2 = bsig0(v_r[0]) + maj_fn(v_r[0], v_r[1], v_r[2]);
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = h_r[i] + v_r[i];
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    win_nxt  = win_r;
    h_nxt    = h_r;
    v_nxt    = v_r;

    if (cmd.push) begin
      pend_nxt = pend_r + 6'd1;
      acc_nxt  = {acc_r[15:0], push_byte};
      // every fourth byte completes a big-endian word
      if (pend_r[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = {acc_r, push_byte};
      end
      if (cmd.src == SRC_DATA) begin
        cnt_nxt = cnt_r + 64'd1;
      end
      if (cmd.src == SRC_LEN) begin
        len_nxt = {len_r[55:0], 8'h00};
      end
    end

    if (cmd.load_len) begin
      len_nxt = {cnt_r[60:0], 3'b000};
      cnt_nxt = '0;
    end

    if (cmd.init_v) begin
      v_nxt = h_r;
    end

    if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[15] = sched_w;
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end

    if (cmd.fold) begin
      if (cmd.fold_last) begin
        h_nxt = HASH_IV;
      end else begin
        h_nxt = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
      h_r    <= HASH_IV;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      h_r    <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    acc_r <= acc_nxt;
    win_r <= win_nxt;
    v_r   <= v_nxt;
  end

endmodule

@@ rtl/shabh_obuf.sv @@
// digest output register: holds eight words and drains them one request at a time
// depends on shabh_pkg
module shabh_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  shabh_pkg::digest_t dig,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output shabh_pkg::word_t   out_word,
  output logic [2:0]         out_index,
  output logic               out_last
);
  import shabh_pkg::*;

  digest_t    dig_r;
  logic [2:0] idx_r;
  logic       busy_r;

  assign busy      = busy_r;
  assign out_valid = busy_r;
  assign out_word  = dig_r[0];
  assign out_index = idx_r;
  assign out_last  = (idx_r == LAST_WORD_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && out_ready) begin
      idx_r <= idx_r + 3'd1;
      if (idx_r == LAST_WORD_IDX) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dig_r <= dig;
    end else if (busy_r && out_ready) begin
      for (int i = 0; i < 7; i++) begin
        dig_r[i] <= dig_r[i + 1];
      end
    end
  end

endmodule

@@ rtl/sha256_byte_stream_hasher_core.sv @@
// top level of the sha-256 byte stream hasher
// depends on shabh_pkg, shabh_if, shabh_ctrl, shabh_dp, shabh_obuf
//
// channel  dir  payload                               request means
// in_ch    in   action, data_byte                     absorb one byte or finish message
// out_ch   out  digest_word, word_index, last_word    one digest word, eight per finish
//
// a data byte is taken while idle; a byte that fills a 64-byte block starts its rounds and
// fold on the single shared round unit, and no request is taken until they end
// a finish pushes one padding byte at a time (9 to 72, length bytes included), checks once
// before the length bytes and runs one or two compressions, then the digest
// moves to the output register
// reset (synchronous, rst_n low) loads the initial hash values and clears all counters
// the output register drains while the next message is absorbed; a finish waits in its
// fold cycle until the previous digest has been fully taken
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  shabh_in_if.sink    in_ch,
  shabh_out_if.source out_ch
);
  import shabh_pkg::*;

  cmd_t    cmd;
  sts_t    sts;
  digest_t dig;
  logic    in_ready;
  logic    out_busy;
  logic    [5:0] pending;

  assign in_ch.ready  = in_ready;
  assign sts.pending  = pending;
  assign sts.out_busy = out_busy;

  // sequencing: intake, padding, 64 rounds, fold
  shabh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // block packing, message schedule and compression
  shabh_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_ch.data_byte),
    .cmd     (cmd),
    .pending (pending),
    .dig     (dig)
  );

  // digest held here so intake of the next message is not blocked
  shabh_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (cmd.fold_last),
    .dig       (dig),
    .busy      (out_busy),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.digest_word),
    .out_index (out_ch.word_index),
    .out_last  (out_ch.last_word)
  );

endmodule

@@ dv/sha256_byte_stream_hasher_core_tb.sv @@
// self-checking testbench of sha256_byte_stream_hasher_core: byte and finish requests in,
// digest words out, each word checked against an sha-256 predictor held in the bench or a typed-in digest
// depends on shabh_pkg, shabh_if and the rtl of the hasher
module sha256_byte_stream_hasher_core_tb;
  import shabh_pkg::*;

  localparam int N_DIRECTED   = 16;
  localparam int N_RANDOM     = 280;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS  = 10;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // one row of the directed table; known marks a digest typed in by hand
  typedef struct packed {
    logic         act;
    logic [7:0]   dbyte;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ACT_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},  // empty message
    '{ACT_ABSORB, 8'h61, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h62, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h63, 1'b0, 256'h0},
    '{ACT_FINISH, 8'hff, 1'b1, ABC_DIGEST},    // byte of a finish is ignored
    '{ACT_FINISH, 8'ha5, 1'b1, EMPTY_DIGEST},  // back to back: hash words start over
    '{ACT_ABSORB, 8'h00, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'hff, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h80, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h7f, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h01, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'hfe, 1'b0, 256'h0},
    '{ACT_FINISH, 8'h00, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'haa, 1'b0, 256'h0},
    '{ACT_ABSORB, 8'h55, 1'b0, 256'h0},
    '{ACT_FINISH, 8'h5a, 1'b0, 256'h0}
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  logic clk;
  logic rst_n;

  shabh_in_if  in_ch ();
  shabh_out_if out_ch ();

  sha256_byte_stream_hasher_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state: chaining words, open block, fill level and message length
  logic [31:0]  hash_words [8];
  logic [7:0]   msg_block [64];
  logic [5:0]   block_fill;
  logic [63:0]  msg_len_bytes;

  digest_beat_t digest_q [$];

  int items_taken;
  int mismatches;
  int cycle_cnt;
  int send_idle_pct;
  int recv_stall_pct;

  always #2 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of msg_block into hash_words
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
    e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
    for (int t = 0; t < 64; t++) begin
      s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + SHA_K[t] + w[t];
      s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++)
      hash_words[i] = SHA_H0[i];
    block_fill    = '0;
    msg_len_bytes = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    msg_len_bytes++;
    if (block_fill == 0)
      compress_block();
  endfunction

  // padding, length, last compression; returns the digest and starts a new message
  function automatic logic [255:0] finish_message();
    int          pos;
    logic [63:0] bit_len;
    logic [255:0] dig;
    pos = block_fill;
    msg_block[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      for (int i = pos; i < 64; i++)
        msg_block[i] = 8'h00;
      compress_block();
      pos = 0;
    end
    for (int i = pos; i < 56; i++)
      msg_block[i] = 8'h00;
    bit_len = msg_len_bytes << 3;
    for (int i = 0; i < 8; i++)
      msg_block[56+i] = bit_len[63-8*i -: 8];
    compress_block();
    dig = {hash_words[0], hash_words[1], hash_words[2], hash_words[3],
           hash_words[4], hash_words[5], hash_words[6], hash_words[7]};
    restart_message();
    return dig;
  endfunction

  function automatic void queue_digest(input logic [255:0] dig);
    digest_beat_t beat;
    for (int i = 0; i < 8; i++) begin
      beat.word = dig[255-32*i -: 32];
      beat.idx  = i[2:0];
      beat.last = (i == 7);
      digest_q.insert(digest_q.size(), beat);
    end
  endfunction

  // present one request from the falling edge on, hold until taken, then predict
  task automatic send_request(input logic act, input logic [7:0] b,
                              input logic known, input logic [255:0] known_dig);
    logic [255:0] dig;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.action    <= 1'($urandom_range(1));
      in_ch.data_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    items_taken++;
    if (act == ACT_ABSORB) begin
      absorb_byte(b);
    end else begin
      dig = finish_message();
      queue_digest(known ? known_dig : dig);
    end
  endtask

  // sender holds off until every digest word in flight has come out
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0)
      @(posedge clk);
  endtask

  // random message: mostly short, some around the padding and block boundaries
  task automatic send_random_message();
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      len = $urandom_range(8);
    end else if (pick < 75) begin
      case ($urandom_range(5))
        0: len = 55;
        1: len = 56;
        2: len = 57;
        3: len = 63;
        4: len = 64;
        default: len = 65;
      endcase
    end else begin
      len = $urandom_range(40, 9);
    end
    for (int i = 0; i < len; i++)
      send_request(ACT_ABSORB, 8'($urandom_range(255)), 1'b0, 256'h0);
    send_request(ACT_FINISH, 8'($urandom_range(255)), 1'b0, 256'h0);
  endtask

  // receiver side: random backpressure set by the current phase
  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_digest
    digest_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected digest word %h index %0d last %0b",
                   out_ch.digest_word, out_ch.word_index, out_ch.last_word);
      end else begin
        want = digest_q.pop_front();
        if (out_ch.digest_word !== want.word || out_ch.word_index !== want.idx ||
            out_ch.last_word !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("digest word mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                     want.word, want.idx, want.last,
                     out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_ABSORB;
    in_ch.data_byte = 8'h00;
    items_taken     = 0;
    mismatches      = 0;
    cycle_cnt       = 0;
    send_idle_pct   = 6;
    recv_stall_pct  = 76;
    restart_message();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed table, expected digest typed in where it is a known vector
    for (int i = 0; i < N_DIRECTED; i++)
      send_request(DIRECTED[i].act, DIRECTED[i].dbyte, DIRECTED[i].known,
                   DIRECTED[i].digest);

    hold_until_drained();

    // random messages in three idling phases: slow receiver, slow sender, none
    while (items_taken < N_DIRECTED + N_RANDOM) begin
      if (items_taken < N_DIRECTED + N_RANDOM / 3) begin
        send_idle_pct  = 6;
        recv_stall_pct = 76;
      end else if (items_taken < N_DIRECTED + 2 * N_RANDOM / 3) begin
        send_idle_pct  = 76;
        recv_stall_pct = 6;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      send_random_message();
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/shabh_pkg.sv
rtl/shabh_if.sv
rtl/shabh_ctrl.sv
rtl/shabh_dp.sv
rtl/shabh_obuf.sv
rtl/sha256_byte_stream_hasher_core.sv
dv/sha256_byte_stream_hasher_core_tb.sv
